### rtl/core/ptw_pkg.sv
// Shared types, constants and helper functions of the four-level page-table walker.
`default_nettype none

package ptw_pkg;

  localparam int unsigned WORD_W          = 64;
  localparam int unsigned IDX_W           = 9;
  localparam int unsigned LVL_W           = 2;
  localparam int unsigned TABLE_WORDS_DEF = 4096;
  localparam int unsigned BIT_PRESENT     = 0;
  localparam int unsigned BIT_SIZE        = 7;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_WRITE     = 1'b1;

  localparam logic CFG_PAGING = 1'b0;
  localparam logic CFG_ROOT   = 1'b1;

  localparam logic [LVL_W-1:0] LVL_L4 = 2'd0;
  localparam logic [LVL_W-1:0] LVL_L3 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_L2 = 2'd2;
  localparam logic [LVL_W-1:0] LVL_L1 = 2'd3;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_PASS  = 2'd1,
    RES_FAULT = 2'd2,
    RES_LEAF  = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic             clear_step;
    logic             capture;
    logic             mem_write;
    logic             mem_read;
    logic             from_entry;
    logic             res_load;
    res_kind_e        res_kind;
    logic             out_load;
    logic [LVL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_write;
    logic paging;
    logic root_ok;
    logic present;
    logic size;
  } sts_t;

  function automatic logic [IDX_W-1:0] level_index(logic [WORD_W-1:0] va,
                                                   logic [LVL_W-1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      LVL_L4:  idx = va[47:39];
      LVL_L3:  idx = va[38:30];
      LVL_L2:  idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [WORD_W-4:0] entry_word(logic [WORD_W-1:0] base,
                                                   logic [IDX_W-1:0] idx);
    return {base[WORD_W-1:12], idx};
  endfunction

  function automatic logic [WORD_W-1:0] leaf_address(logic [WORD_W-1:0] entry,
                                                     logic [WORD_W-1:0] va,
                                                     logic [LVL_W-1:0] level);
    logic [WORD_W-1:0] pa;
    case (level)
      LVL_L3:  pa = {entry[WORD_W-1:30], va[29:0]};
      LVL_L2:  pa = {entry[WORD_W-1:21], va[20:0]};
      default: pa = {entry[WORD_W-1:12], va[11:0]};
    endcase
    return pa;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ptw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/ptw_dpath.sv
// Datapath of the page-table walker: configuration, item registers, table RAM and results.
`default_nettype none

module ptw_dpath #(
  parameter int unsigned TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [ptw_pkg::WORD_W-1:0]  cfg_data_i,
  input  wire logic                        opcode_i,
  input  wire logic [ptw_pkg::WORD_W-1:0]  address_i,
  input  wire logic [ptw_pkg::WORD_W-1:0]  write_data_i,
  input  wire ptw_pkg::cmd_t               cmd_i,
  output ptw_pkg::sts_t                    sts_o,
  output logic      [ptw_pkg::WORD_W-1:0]  phys_address_o,
  output logic                             fault_o
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  logic                        paging_q, paging_d;
  logic [ptw_pkg::WORD_W-1:0]  root_q, root_d;
  logic [AW-1:0]               clr_cnt_q, clr_cnt_d;
  logic                        op_q, op_d;
  logic [ptw_pkg::WORD_W-1:0]  va_q, va_d;
  logic [ptw_pkg::WORD_W-1:0]  wdata_q, wdata_d;
  logic [ptw_pkg::WORD_W-1:0]  res_pa_q, res_pa_d;
  logic                        res_fault_q, res_fault_d;
  logic [ptw_pkg::WORD_W-1:0]  out_pa_q, out_pa_d;
  logic                        out_fault_q, out_fault_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ptw_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ptw_pkg::WORD_W-1:0]  rdata;
  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [ptw_pkg::WORD_W-1:0]  read_base;
  logic [ptw_pkg::WORD_W-4:0]  read_word;

  always_comb begin
    paging_d = paging_q;
    root_d   = root_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ptw_pkg::CFG_PAGING: paging_d = cfg_data_i[0];
        ptw_pkg::CFG_ROOT:   root_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clear_step) begin
      clr_cnt_d = clr_cnt_q + {{(AW-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    op_d    = op_q;
    va_d    = va_q;
    wdata_d = wdata_q;
    if (cmd_i.capture) begin
      op_d    = opcode_i;
      va_d    = address_i;
      wdata_d = write_data_i;
    end
  end

  assign ram_we    = cmd_i.clear_step | cmd_i.mem_write;
  assign ram_waddr = cmd_i.clear_step ? clr_cnt_q : va_q[AW+2:3];
  assign ram_wdata = cmd_i.clear_step ? '0 : wdata_q;

  assign idx       = ptw_pkg::level_index(va_q, cmd_i.level);
  assign read_base = cmd_i.from_entry ? rdata : root_q;
  assign read_word = ptw_pkg::entry_word(read_base, idx);
  assign ram_raddr = read_word[AW-1:0];

  ptw_ram #(
    .WIDTH (ptw_pkg::WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.mem_read),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    res_pa_d    = res_pa_q;
    res_fault_d = res_fault_q;
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        ptw_pkg::RES_ZERO: begin
          res_pa_d    = '0;
          res_fault_d = 1'b0;
        end
        ptw_pkg::RES_PASS: begin
          res_pa_d    = va_q;
          res_fault_d = 1'b0;
        end
        ptw_pkg::RES_FAULT: begin
          res_pa_d    = '0;
          res_fault_d = 1'b1;
        end
        ptw_pkg::RES_LEAF: begin
          res_pa_d    = ptw_pkg::leaf_address(rdata, va_q, cmd_i.level);
          res_fault_d = 1'b0;
        end
        default: begin
          res_pa_d    = '0;
          res_fault_d = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_pa_d    = out_pa_q;
    out_fault_d = out_fault_q;
    if (cmd_i.out_load) begin
      out_pa_d    = res_pa_q;
      out_fault_d = res_fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q  <= 1'b0;
      root_q    <= '0;
      clr_cnt_q <= '0;
    end else begin
      paging_q  <= paging_d;
      root_q    <= root_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    va_q        <= va_d;
    wdata_q     <= wdata_d;
    res_pa_q    <= res_pa_d;
    res_fault_q <= res_fault_d;
    out_pa_q    <= out_pa_d;
    out_fault_q <= out_fault_d;
  end

  always_comb begin
    sts_o.clear_last = (clr_cnt_q == {AW{1'b1}});
    sts_o.op_write   = (op_q == ptw_pkg::OP_WRITE);
    sts_o.paging     = paging_q;
    sts_o.root_ok    = root_q[ptw_pkg::BIT_PRESENT] & ~root_q[ptw_pkg::BIT_SIZE];
    sts_o.present    = rdata[ptw_pkg::BIT_PRESENT];
    sts_o.size       = rdata[ptw_pkg::BIT_SIZE];
  end

  assign phys_address_o = out_pa_q;
  assign fault_o        = out_fault_q;

endmodule

`default_nettype wire

### rtl/core/ptw_ctrl.sv
// Controller state machine of the page-table walker: clearing pass, walk sequencing, output slot.
`default_nettype none

module ptw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output ptw_pkg::cmd_t      cmd_o,
  input  wire ptw_pkg::sts_t sts_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [ptw_pkg::LVL_W-1:0] level_q, level_d;
  logic                      leaf_q, leaf_d;
  logic                      out_valid_q, out_valid_d;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    level_d  = level_q;
    leaf_d   = leaf_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (sts_i.op_write) begin
          cmd_o.mem_write = 1'b1;
          cmd_o.res_load  = 1'b1;
          cmd_o.res_kind  = ptw_pkg::RES_ZERO;
          state_d         = S_DONE;
        end else if (!sts_i.paging) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ptw_pkg::RES_PASS;
          state_d        = S_DONE;
        end else if (!sts_i.root_ok) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ptw_pkg::RES_FAULT;
          state_d        = S_DONE;
        end else begin
          cmd_o.mem_read = 1'b1;
          cmd_o.level    = ptw_pkg::LVL_L4;
          level_d        = ptw_pkg::LVL_L4;
          leaf_d         = 1'b0;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts_i.present) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ptw_pkg::RES_FAULT;
          state_d        = S_DONE;
        end else if (leaf_q || (level_q == ptw_pkg::LVL_L1)) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ptw_pkg::RES_LEAF;
          cmd_o.level    = level_q;
          state_d        = S_DONE;
        end else begin
          cmd_o.mem_read   = 1'b1;
          cmd_o.from_entry = 1'b1;
          cmd_o.level      = level_q + 2'd1;
          level_d          = level_q + 2'd1;
          leaf_d           = sts_i.size && (level_q != ptw_pkg::LVL_L2);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      level_q     <= ptw_pkg::LVL_L4;
      leaf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      leaf_q      <= leaf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/four_level_page_table_walker.sv
// Top level of the four-level page-table walker.
//
//  Channel  Direction  Handshake                Payload
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  in       in         in_valid_i/in_ready_o    opcode_i, address_i, write_data_i
//  out      out        out_valid_o/out_ready_i  phys_address_o, fault_o
//
// After reset the table RAM is cleared one word a cycle, with in_ready_o low.
// A write, a pass-through or a root fault loads its result in S_START and reaches the output register from S_DONE.
// A walk makes n table reads (n from 1 to 4), one read per cycle on the RAM port.
// The next transaction is accepted in the cycle after the result enters the output register.
// A stalled output holds the walker in its final state until the output register frees up.
// Configuration transactions are always accepted.
`default_nettype none

module four_level_page_table_walker #(
  parameter int unsigned TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic                       cfg_index_i,
  input  wire logic [ptw_pkg::WORD_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       opcode_i,
  input  wire logic [ptw_pkg::WORD_W-1:0] address_i,
  input  wire logic [ptw_pkg::WORD_W-1:0] write_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [ptw_pkg::WORD_W-1:0] phys_address_o,
  output logic                            fault_o
);

  ptw_pkg::cmd_t cmd;
  ptw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ptw_dpath #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .phys_address_o (phys_address_o),
    .fault_o        (fault_o)
  );

endmodule

`default_nettype wire

### rtl/core/ptw_chk.sv
// Port-level assertion checker of the page-table walker and its bind statement.
`default_nettype none

module ptw_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [ptw_pkg::WORD_W-1:0] phys_address_o,
  input wire logic                       fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(phys_address_o) && $stable(fault_o))
    else $error("Output payload changed while stalled.");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> phys_address_o == '0)
    else $error("Faulting result carries a nonzero address.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted again while the previous transaction is in work.");

endmodule

bind four_level_page_table_walker ptw_chk u_ptw_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .phys_address_o (phys_address_o),
  .fault_o        (fault_o)
);

`default_nettype wire

### test/tb_four_level_page_table_walker.sv
// Self-checking testbench of the four-level page-table walker with a scoreboard class.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;

  localparam int unsigned WORD_W    = ptw_pkg::WORD_W;
  localparam int unsigned IDX_W     = ptw_pkg::IDX_W;
  localparam int unsigned MEM_WORDS = ptw_pkg::TABLE_WORDS_DEF;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  class translation_scoreboard;
    logic [WORD_W-1:0] table_mem [MEM_WORDS];
    logic              paging_on;
    logic [WORD_W-1:0] root_entry;
    logic [WORD_W-1:0] pending_phys_q [$];
    logic              pending_fault_q [$];
    int unsigned       errors;

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      paging_on  = 1'b0;
      root_entry = '0;
      errors     = 0;
    endfunction

    function void note_config(logic index, logic [WORD_W-1:0] value);
      if (index == ptw_pkg::CFG_PAGING) begin
        paging_on = value[0];
      end else begin
        root_entry = value;
      end
    endfunction

    function void accept_request(logic op, logic [WORD_W-1:0] va, logic [WORD_W-1:0] data);
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] entry;
      logic [WORD_W-1:0] pa;
      logic [WORD_W-1:0] span;
      logic [MEM_AW-1:0] word;
      logic              ok;
      logic              leaf_next;
      logic              done;
      int unsigned       lvl;
      int unsigned       shift;
      pa = '0;
      ok = 1'b1;
      if (op == ptw_pkg::OP_WRITE) begin
        table_mem[MEM_AW'(va >> 3)] = data;
      end else if (!paging_on) begin
        pa = va;
      end else begin
        base      = root_entry;
        ok        = root_entry[ptw_pkg::BIT_PRESENT] && !root_entry[ptw_pkg::BIT_SIZE];
        leaf_next = 1'b0;
        done      = 1'b0;
        lvl       = 0;
        // A size bit in the first or second entry makes the next read the leaf.
        while (ok && !done) begin
          shift = 39 - 9 * lvl;
          word  = MEM_AW'({base[WORD_W-1:12], va[shift +: IDX_W]});
          entry = table_mem[word];
          ok    = entry[ptw_pkg::BIT_PRESENT];
          if (leaf_next || lvl == 3) begin
            span = (64'd1 << shift) - 64'd1;
            pa   = (entry & ~span) | (va & span);
            done = 1'b1;
          end else begin
            leaf_next = (lvl < 2) && entry[ptw_pkg::BIT_SIZE];
            base      = entry;
            lvl++;
          end
        end
        if (!ok) pa = '0;
      end
      pending_phys_q.push_back(pa);
      pending_fault_q.push_back(!ok);
    endfunction

    function void check_translation(logic [WORD_W-1:0] pa, logic fault);
      logic [WORD_W-1:0] want_pa;
      logic              want_fault;
      if (pending_phys_q.size() == 0) begin
        $error("unexpected result transaction: phys_address %h fault %b", pa, fault);
        errors++;
      end else begin
        want_pa    = pending_phys_q.pop_front();
        want_fault = pending_fault_q.pop_front();
        if (pa !== want_pa) begin
          $error("phys_address expected %h actual %h", want_pa, pa);
          errors++;
        end
        if (fault !== want_fault) begin
          $error("fault expected %b actual %b", want_fault, fault);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i  = ptw_pkg::CFG_PAGING;
  logic [WORD_W-1:0] cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              opcode_i     = ptw_pkg::OP_TRANSLATE;
  logic [WORD_W-1:0] address_i    = '0;
  logic [WORD_W-1:0] write_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [WORD_W-1:0] phys_address_o;
  logic              fault_o;

  bit          tx_idle          = 1'b1;
  bit          rx_idle          = 1'b1;
  int unsigned sink_hold_cycles = 0;

  translation_scoreboard sb = new();

  four_level_page_table_walker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .phys_address_o (phys_address_o),
    .fault_o        (fault_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.note_config(cfg_index_i, cfg_data_i);
      if (out_valid_o && out_ready_i) sb.check_translation(phys_address_o, fault_o);
      if (in_valid_i && in_ready_o) sb.accept_request(opcode_i, address_i, write_data_i);
    end
  end

  initial begin : result_sink
    int unsigned gap;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        gap              = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(19, 0) : 0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [WORD_W-1:0] make_entry(logic [2:0] tbl, logic size, logic present);
    logic [WORD_W-1:0] e;
    e                      = rand64();
    e[14:12]               = tbl;
    e[ptw_pkg::BIT_SIZE]    = size;
    e[ptw_pkg::BIT_PRESENT] = present;
    return e;
  endfunction

  function automatic logic [WORD_W-1:0] entry_addr(logic [2:0] tbl, logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] a;
    a        = rand64();
    a[14:12] = tbl;
    a[11:3]  = idx;
    return a;
  endfunction

  function automatic logic [WORD_W-1:0] make_va(logic [IDX_W-1:0] i4, logic [IDX_W-1:0] i3,
                                                logic [IDX_W-1:0] i2, logic [IDX_W-1:0] i1);
    logic [WORD_W-1:0] v;
    v        = rand64();
    v[47:12] = {i4, i3, i2, i1};
    return v;
  endfunction

  task automatic send_item(logic op, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] data);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(19, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_phys_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(logic paging, logic [WORD_W-1:0] root);
    logic [WORD_W-1:0] paging_word;
    drain();
    paging_word    = rand64();
    paging_word[0] = paging;
    cfg_valid_i   <= 1'b1;
    cfg_index_i   <= ptw_pkg::CFG_PAGING;
    cfg_data_i    <= paging_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i   <= ptw_pkg::CFG_ROOT;
    cfg_data_i    <= root;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [IDX_W-1:0]  idx_pool [3];
    logic [WORD_W-1:0] root;
    logic [WORD_W-1:0] va;
    int unsigned       pick;
    int unsigned       phase;
    int unsigned       n;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ptw_pkg::OP_TRANSLATE, '1, rand64());
    send_item(ptw_pkg::OP_TRANSLATE, '0, rand64());
    send_item(ptw_pkg::OP_WRITE, '1, '1);
    send_item(ptw_pkg::OP_WRITE, '0, '0);
    configure(1'b1, '0);
    send_item(ptw_pkg::OP_TRANSLATE, rand64(), rand64());
    configure(1'b1, 64'hFFFF_FFFF_FFFF_F07E);
    send_item(ptw_pkg::OP_TRANSLATE, rand64(), rand64());
    configure(1'b1, '1);
    send_item(ptw_pkg::OP_TRANSLATE, rand64(), rand64());
    configure(1'b1, make_entry(3'd0, 1'b0, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE,
              make_va(9'd5, 9'($urandom()), 9'($urandom()), 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd0, 9'd5), make_entry(3'd1, 1'b1, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE,
              make_va(9'd5, 9'd9, 9'($urandom()), 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd1, 9'd9),
              make_entry(3'($urandom()), 1'b0, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE,
              make_va(9'd5, 9'd9, 9'($urandom()), 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd0, 9'd6), make_entry(3'd2, 1'b0, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE,
              make_va(9'd6, 9'd100, 9'($urandom()), 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd2, 9'd3), make_entry(3'd3, 1'b1, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE, make_va(9'd6, 9'd3, 9'd7, 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd3, 9'd7),
              make_entry(3'($urandom()), 1'b0, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE, make_va(9'd6, 9'd3, 9'd7, 9'($urandom())), rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd2, 9'd4), make_entry(3'd4, 1'b0, 1'b1));
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd4, 9'd8), make_entry(3'd5, 1'b1, 1'b1));
    va = make_va(9'd6, 9'd4, 9'd8, 9'd2);
    send_item(ptw_pkg::OP_TRANSLATE, va, rand64());
    send_item(ptw_pkg::OP_WRITE, entry_addr(3'd5, 9'd2),
              make_entry(3'($urandom()), 1'b1, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE, va, rand64());
    configure(1'b0, make_entry(3'd0, 1'b0, 1'b1));
    send_item(ptw_pkg::OP_TRANSLATE, va, rand64());

    for (phase = 0; phase < 12; phase++) begin
      tx_idle = (phase % 4) != 3;
      rx_idle = (phase % 3) != 2;
      pick    = $urandom_range(9, 0);
      if (pick == 0) begin
        root = '0;
      end else if (pick == 1) begin
        root = '1;
      end else if (pick == 2) begin
        root    = rand64();
        root[0] = 1'b0;
      end else begin
        root = make_entry(3'($urandom()), 1'b0, 1'b1);
      end
      configure($urandom_range(5, 0) != 0, root);
      foreach (idx_pool[k]) begin
        if ($urandom_range(3, 0) == 0) begin
          idx_pool[k] = $urandom_range(1, 0) ? 9'h1ff : 9'h000;
        end else begin
          idx_pool[k] = 9'($urandom());
        end
      end
      // The sink holds off for a long stretch so that the walker backs up.
      if (phase == 5) begin
        sink_hold_cycles = 400;
        tx_idle          = 1'b0;
      end
      for (n = 0; n < 125; n++) begin
        if (n == 60) drain();
        pick = $urandom_range(19, 0);
        if (pick < 7) begin
          send_item(ptw_pkg::OP_WRITE,
                    entry_addr(3'($urandom()), idx_pool[$urandom_range(2, 0)]),
                    make_entry(3'($urandom()), $urandom_range(3, 0) == 0,
                               $urandom_range(9, 0) != 0));
        end else if (pick < 16) begin
          send_item(ptw_pkg::OP_TRANSLATE,
                    make_va(idx_pool[$urandom_range(2, 0)], idx_pool[$urandom_range(2, 0)],
                            idx_pool[$urandom_range(2, 0)], idx_pool[$urandom_range(2, 0)]),
                    rand64());
        end else if (pick < 18) begin
          send_item(ptw_pkg::OP_TRANSLATE, rand64(), rand64());
        end else begin
          send_item(ptw_pkg::OP_WRITE, rand64(), rand64());
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_phys_q.size() == 0) begin
      $display("** four_level_page_table_walker: PASSED **");
    end else begin
      $display("** four_level_page_table_walker: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("** four_level_page_table_walker: FAILED **");
    $finish;
  end

endmodule
